[rtl/core/bar_graph_led_strip_encoder_assert.svh]
// Assertion macros for the bar graph LED strip encoder checker.
`ifndef BAR_GRAPH_LED_STRIP_ENCODER_ASSERT_SVH
`define BAR_GRAPH_LED_STRIP_ENCODER_ASSERT_SVH

// Checked while reset is released.
`define BGLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bgle: assertion failed");

// Checked at every edge, reset included.
`define BGLE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bgle: assertion failed");

`endif

[rtl/core/bgle_pkg.sv]
`timescale 1ns / 1ps
package bgle_pkg;

    localparam int NUM_COLUMNS     = 32;
    localparam int ROWS            = 8;
    localparam int NUM_BARS        = 11;
    localparam int COL_W           = $clog2(NUM_COLUMNS);
    localparam int ROW_W           = $clog2(ROWS);
    localparam int NUM_PIXELS      = NUM_COLUMNS * ROWS;
    localparam int CODES_PER_PIXEL = 24;
    localparam int CODE_W          = $clog2(CODES_PER_PIXEL);
    localparam int CMDQ_DEPTH      = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ONE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ZERO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 2'd2;

    localparam logic [7:0] DUTY_ONE_RST  = 8'd64;
    localparam logic [7:0] DUTY_ZERO_RST = 8'd32;
    localparam logic [7:0] LEVEL_RST     = 8'b1111_0000;

    localparam logic [1:0] MODE_SET_BAR    = 2'd0;
    localparam logic [1:0] MODE_CLR_MATRIX = 2'd1;
    localparam logic [1:0] MODE_CLR_SHOWN  = 2'd2;
    localparam logic [1:0] MODE_READ       = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] bar;
        logic [3:0] amp;
        logic [7:0] position;
    } t_in;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [7:0] duty_one;
        logic [7:0] duty_zero;
        logic [7:0] level;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_SET_BAR,
        OP_CLR_MATRIX,
        OP_CLR_SHOWN,
        OP_READ
    } t_op;

    // Decoded command handed from front to back.
    typedef struct packed {
        t_op              op;
        logic             col_a_ok;
        logic [COL_W-1:0] col_a;
        logic             col_b_ok;
        logic [COL_W-1:0] col_b;
        logic [ROWS-1:0]  height;
        logic             pix_ok;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] idx;
        logic             g_on;
        logic             r_on;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_bk_state;

endpackage

[rtl/core/bgle_front.sv]
`timescale 1ns / 1ps
module bgle_front (
    input  bgle_pkg::t_in  i_item,
    output bgle_pkg::t_cmd o_cmd
);
    import bgle_pkg::*;

    localparam int BASE_W = $clog2(3 * 16);

    logic              w_bar_ok;
    logic [BASE_W-1:0] w_base;
    logic [7:0]        w_col_full;
    logic [ROW_W-1:0]  w_idx;
    logic [ROW_W-1:0]  w_row;

    always_comb begin
        w_bar_ok   = (i_item.bar != 4'd0) && (int'(i_item.bar) <= NUM_BARS);
        w_base     = BASE_W'(3 * int'(i_item.bar) - 3);
        w_col_full = 8'(i_item.position / ROWS);
        w_idx      = ROW_W'(i_item.position % ROWS);
        // odd columns run downward
        w_row      = w_col_full[0] ? (ROW_W'(ROWS - 1) - w_idx) : w_idx;
    end

    always_comb begin
        case (i_item.mode)
            MODE_SET_BAR:    o_cmd.op = OP_SET_BAR;
            MODE_CLR_MATRIX: o_cmd.op = OP_CLR_MATRIX;
            MODE_CLR_SHOWN:  o_cmd.op = OP_CLR_SHOWN;
            default:         o_cmd.op = OP_READ;
        endcase
        o_cmd.col_a_ok = w_bar_ok && (int'(w_base) < NUM_COLUMNS);
        o_cmd.col_b_ok = w_bar_ok && (int'(w_base) + 1 < NUM_COLUMNS);
        o_cmd.col_a    = COL_W'(w_base);
        o_cmd.col_b    = COL_W'(int'(w_base) + 1);
        // rows 0..amp-1, saturating at the top row
        for (int i = 0; i < ROWS; i++) begin
            o_cmd.height[i] = int'(i_item.amp) > i;
        end
        o_cmd.pix_ok = int'(i_item.position) < NUM_PIXELS;
        o_cmd.col    = COL_W'(w_col_full);
        o_cmd.idx    = w_idx;
        o_cmd.g_on   = int'(w_row) < ROWS - 1;
        o_cmd.r_on   = int'(w_row) >= ROWS / 2;
    end

endmodule

[rtl/core/bgle_cmd_fifo.sv]
`timescale 1ns / 1ps
module bgle_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bgle_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output bgle_pkg::t_cmd o_data,
    output logic           o_empty
);
    import bgle_pkg::*;

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = r_count == CNT_W'(CMDQ_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[rtl/core/bgle_back.sv]
`timescale 1ns / 1ps
module bgle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bgle_pkg::t_cfg i_cfg,
    input  bgle_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_pop,
    output bgle_pkg::t_out o_item,
    output logic           o_empty,
    input  logic           i_pop
);
    import bgle_pkg::*;

    localparam logic [CODE_W-1:0] CODE_LAST = CODE_W'(CODES_PER_PIXEL - 1);

    t_bk_state                  r_state;
    t_bk_state                  n_state;
    logic [ROWS-1:0]            r_lit   [NUM_COLUMNS];
    logic [ROWS-1:0]            n_lit   [NUM_COLUMNS];
    logic [ROWS-1:0]            r_shown [NUM_COLUMNS];
    logic [ROWS-1:0]            n_shown [NUM_COLUMNS];
    logic [CODES_PER_PIXEL-1:0] r_bits;
    logic [CODE_W-1:0]          r_cnt;
    t_out                       r_out;
    logic                       r_out_valid;

    logic       w_slot_free;
    logic       w_take;
    logic       w_emit;
    logic       w_px_lit;
    logic [7:0] w_g;
    logic [7:0] w_r;

    function automatic logic [ROWS-1:0] flip_rows(input logic [ROWS-1:0] v);
        logic [ROWS-1:0] f;
        for (int i = 0; i < ROWS; i++) begin
            f[ROWS-1-i] = v[i];
        end
        return f;
    endfunction

    assign w_slot_free = !r_out_valid || i_pop;
    assign o_item      = r_out;
    assign o_empty     = !r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && (i_cmd.op == OP_READ)) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_slot_free && (r_cnt == CODE_LAST)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_take = 1'b0;
        w_emit = 1'b0;
        case (r_state)
            BK_IDLE: w_take = i_cmd_valid;
            BK_EMIT: w_emit = w_slot_free;
            default: begin
                w_take = 1'b0;
                w_emit = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop = w_take;

    // matrix and shown map updates
    always_comb begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            n_lit[c] = r_lit[c];
        end
        if (w_take && (i_cmd.op == OP_SET_BAR)) begin
            if (i_cmd.col_a_ok) begin
                n_lit[i_cmd.col_a] = r_lit[i_cmd.col_a] | i_cmd.height;
            end
            if (i_cmd.col_b_ok) begin
                n_lit[i_cmd.col_b] = r_lit[i_cmd.col_b] | i_cmd.height;
            end
        end else if (w_take && (i_cmd.op == OP_CLR_MATRIX)) begin
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                n_lit[c] = '0;
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            n_shown[c] = r_shown[c];
            if (w_take && (i_cmd.op == OP_SET_BAR)) begin
                n_shown[c] = r_shown[c] | ((c % 2 == 1) ? flip_rows(n_lit[c]) : n_lit[c]);
            end else if (w_take && (i_cmd.op == OP_CLR_SHOWN)) begin
                n_shown[c] = '0;
            end
        end
    end

    // pixel colour
    always_comb begin
        w_px_lit = i_cmd.pix_ok && r_shown[i_cmd.col][i_cmd.idx];
        w_g      = (w_px_lit && i_cmd.g_on) ? i_cfg.level : 8'd0;
        w_r      = (w_px_lit && i_cmd.r_on) ? i_cfg.level : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_lit[c]   <= '0;
                r_shown[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_lit   <= n_lit;
            r_shown <= n_shown;
            if (w_take && (i_cmd.op == OP_READ)) begin
                r_cnt <= '0;
            end else if (w_emit) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: G, R, B bytes, MSB first
    always_ff @(posedge i_clk) begin
        if (w_take && (i_cmd.op == OP_READ)) begin
            r_bits <= {w_g, w_r, 8'd0};
        end else if (w_emit) begin
            r_bits <= r_bits << 1;
        end
        if (w_emit) begin
            r_out.duty <= r_bits[CODES_PER_PIXEL-1] ? i_cfg.duty_one : i_cfg.duty_zero;
            r_out.last <= r_cnt == CODE_LAST;
        end
    end

endmodule

[rtl/core/bar_graph_led_strip_encoder.sv]
`timescale 1ns / 1ps
// Channel   | Handshake             | Payload
// ----------+-----------------------+-------------------------------------
// input     | push / full           | i_item  (mode, bar, amp, position)
// result    | empty / pop           | o_item  (duty, last)
// config    | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// Set-bar and clear items are taken by the back end while idle. A read
// fetches the pixel, then the bit serializer emits 24 codes, one code per
// cycle while pop stays high. Synchronous active-low reset clears both maps
// (flip-flops) and all control at once, no clearing sweep. A low pop holds
// the current code; the two-entry command queue keeps taking items while
// the back end stalls, until it fills.
module bar_graph_led_strip_encoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  bgle_pkg::t_in                       i_item,
    output logic                                empty,
    input  logic                                pop,
    output bgle_pkg::t_out                      o_item,
    input  logic                                i_cfg_we,
    input  logic [bgle_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bgle_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bgle_pkg::*;

    t_cfg r_cfg;
    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_q_empty;
    logic w_q_pop;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_one  <= DUTY_ONE_RST;
            r_cfg.duty_zero <= DUTY_ZERO_RST;
            r_cfg.level     <= LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DUTY_ONE:  r_cfg.duty_one  <= i_cfg_data;
                CFG_DUTY_ZERO: r_cfg.duty_zero <= i_cfg_data;
                CFG_LEVEL:     r_cfg.level     <= i_cfg_data;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // front: decode mode, bar columns, height mask, pixel address and colour
    bgle_front u_front (
        .i_item (i_item),
        .o_cmd  (w_front_cmd)
    );

    // short queue decoupling front from back
    bgle_cmd_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_cmd),
        .o_empty (w_q_empty)
    );

    // back: map updates and code serializer with output register
    bgle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_q_cmd),
        .i_cmd_valid (!w_q_empty),
        .o_cmd_pop   (w_q_pop),
        .o_item      (o_item),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

[rtl/core/bgle_checker.sv]
`timescale 1ns / 1ps
`include "bar_graph_led_strip_encoder_assert.svh"
module bgle_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  logic           full,
    input  logic           empty,
    input  logic           pop,
    input  bgle_pkg::t_out o_item
);
    import bgle_pkg::*;

    // no result and an open queue right after reset
    `BGLE_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty)
    `BGLE_ASSERT_ALWAYS(a_rst_not_full, i_clk, !i_rst_n |=> !full)

    // a stalled code holds
    `BGLE_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_item)))

    // codes of one pixel follow without a gap once taken
    `BGLE_ASSERT(a_burst, i_clk, i_rst_n, (!empty && pop && !o_item.last) |=> !empty)

endmodule

bind bar_graph_led_strip_encoder bgle_checker u_bgle_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_item  (o_item)
);

[sim/bar_graph_led_strip_encoder_tb.sv]
`timescale 1ns / 1ps
module bar_graph_led_strip_encoder_tb;
    import bgle_pkg::*;

    localparam int DRAIN_CYCLES = 16;    // back end plus two-entry command queue, with margin
    localparam int LONG_HOLD    = 160;   // receiver hold-off that fills the block
    localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side

    // Tracks the lit matrix, the shown map and the registers, and queues the
    // duty codes that each read must produce.
    class pixel_scoreboard;
        logic [7:0] lit_cols   [NUM_COLUMNS];
        logic [7:0] shown_cols [NUM_COLUMNS];
        logic [7:0] duty_one;
        logic [7:0] duty_zero;
        logic [7:0] level;
        t_out       code_q [$];
        int         errors;
        int         codes_seen;

        function new();
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                lit_cols[c]   = '0;
                shown_cols[c] = '0;
            end
            duty_one   = DUTY_ONE_RST;
            duty_zero  = DUTY_ZERO_RST;
            level      = LEVEL_RST;
            errors     = 0;
            codes_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_DUTY_ONE:  duty_one  = val;
                CFG_DUTY_ZERO: duty_zero = val;
                CFG_LEVEL:     level     = val;
                default: ;
            endcase
        endfunction

        function void note_item(t_in it);
            t_op            op;
            int             h;
            int             col;
            int             idx;
            int             row;
            logic [ROWS:0]  span;
            logic [7:0]     mask;
            logic [7:0]     v;
            logic [7:0]     flipped;
            logic [7:0]     g;
            logic [7:0]     r;
            logic [7:0]     chan;
            t_out           code;
            op = t_op'(it.mode);
            case (op)
                OP_SET_BAR: begin
                    h    = (it.amp > ROWS) ? ROWS : int'(it.amp);
                    span = (ROWS+1)'((1 << h) - 1);
                    mask = span[ROWS-1:0];
                    if (it.bar >= 1 && it.bar <= NUM_BARS) begin
                        col = 3 * it.bar - 3;
                        if (col < NUM_COLUMNS) lit_cols[col] |= mask;
                        col = 3 * it.bar - 2;
                        if (col < NUM_COLUMNS) lit_cols[col] |= mask;
                    end
                    // odd columns run downward in strip order
                    for (int c = 0; c < NUM_COLUMNS; c++) begin
                        v = lit_cols[c];
                        for (int k = 0; k < ROWS; k++) flipped[k] = v[ROWS-1-k];
                        shown_cols[c] |= c[0] ? flipped : v;
                    end
                end
                OP_CLR_MATRIX: begin
                    for (int c = 0; c < NUM_COLUMNS; c++) lit_cols[c] = '0;
                end
                OP_CLR_SHOWN: begin
                    for (int c = 0; c < NUM_COLUMNS; c++) shown_cols[c] = '0;
                end
                default: begin
                    g = '0;
                    r = '0;
                    if (int'(it.position) < NUM_PIXELS) begin
                        col = it.position / ROWS;
                        idx = it.position % ROWS;
                        if (shown_cols[col][idx]) begin
                            row = (col % 2) ? (ROWS - 1 - idx) : idx;
                            if (row < ROWS - 1)  g = level;
                            if (row >= ROWS / 2) r = level;
                        end
                    end
                    // G, R, then B (never lit), each MSB first
                    for (int i = 0; i < CODES_PER_PIXEL; i++) begin
                        chan      = (i < 8) ? g : (i < 16) ? r : 8'h00;
                        code.duty = chan[7 - (i % 8)] ? duty_one : duty_zero;
                        code.last = (i == CODES_PER_PIXEL - 1);
                        code_q.push_back(code);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_code(t_out got);
            t_out want;
            if (code_q.size() == 0) begin
                report($sformatf("code %0d duty %0d last %0d with nothing expected",
                                 codes_seen, got.duty, got.last));
            end else begin
                want = code_q.pop_front();
                if (got.duty !== want.duty)
                    report($sformatf("code %0d duty %0d, want %0d",
                                     codes_seen, got.duty, want.duty));
                if (got.last !== want.last)
                    report($sformatf("code %0d last %0d, want %0d",
                                     codes_seen, got.last, want.last));
            end
            codes_seen++;
        endtask
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   push       = 1'b0;
    logic                   pop        = 1'b0;
    t_in                    i_item     = '0;
    logic                   i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   full;
    logic                   empty;
    t_out                   o_item;

    pixel_scoreboard sb;
    bit tx_idle_on  = 1'b0;
    bit rx_stall_on = 1'b0;
    bit long_hold   = 1'b0;
    int quiet       = 0;

    bar_graph_led_strip_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no item moves for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: pops codes, checks them, and stalls in bursts or on request.
    initial begin
        int hold;
        hold = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_code(o_item);
            if (long_hold) begin
                hold      = LONG_HOLD;
                long_hold = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 7);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic t_in mk(logic [1:0] mode, logic [3:0] bar, logic [3:0] amp,
                               logic [7:0] position);
        t_in it;
        it.mode     = mode;
        it.bar      = bar;
        it.amp      = amp;
        it.position = position;
        return it;
    endfunction

    // Mostly valid bars and reads, with some stray bar numbers and clears.
    function automatic t_in random_item();
        t_in it;
        int  pick;
        pick        = $urandom_range(0, 99);
        it.bar      = 4'($urandom_range(1, NUM_BARS));
        it.amp      = 4'($urandom_range(0, 15));
        it.position = 8'($urandom_range(0, 255));
        if (pick < 40) begin
            it.mode = MODE_SET_BAR;
            if (pick < 6) it.bar = 4'($urandom_range(0, 15));
        end else if (pick < 47) begin
            it.mode = MODE_CLR_MATRIX;
        end else if (pick < 51) begin
            it.mode = MODE_CLR_SHOWN;
        end else begin
            it.mode = MODE_READ;
        end
        return it;
    endfunction

    // Drives push and the item; returns once the block has taken the item.
    task send_item(input t_in it);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
    endtask

    task run_random(input int n);
        for (int i = 0; i < n; i++) send_item(random_item());
    endtask

    // Sender stops until every code has arrived and the back end has gone quiet.
    task wait_idle();
        push <= 1'b0;
        while (sb.code_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_regs(input logic [7:0] d1, input logic [7:0] d0, input logic [7:0] lv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DUTY_ONE;
        i_cfg_data <= d1;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DUTY_ZERO;
        i_cfg_data <= d0;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LEVEL;
        i_cfg_data <= lv;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(CFG_DUTY_ONE, d1);
        sb.set_reg(CFG_DUTY_ZERO, d0);
        sb.set_reg(CFG_LEVEL, lv);
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;

        // Directed: reset registers, unlit reads, ignored bars, saturation,
        // both column directions, all three colors, sticky shown map, clears.
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_SET_BAR,    4'd0,  4'd8,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_SET_BAR,    4'd1,  4'd15, 8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd4));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd7));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd8));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd15));
        send_item(mk(MODE_SET_BAR,    4'd11, 4'd3,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd240));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd255));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd248));
        send_item(mk(MODE_SET_BAR,    4'd12, 4'd5,  8'd0));
        send_item(mk(MODE_SET_BAR,    4'd15, 4'd0,  8'd0));
        send_item(mk(MODE_SET_BAR,    4'd5,  4'd0,  8'd0));
        send_item(mk(MODE_CLR_MATRIX, 4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_SET_BAR,    4'd2,  4'd2,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd24));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd33));
        send_item(mk(MODE_CLR_SHOWN,  4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd0));
        send_item(mk(MODE_READ,       4'd0,  4'd0,  8'd24));
        wait_idle();

        write_regs(8'hFF, 8'h00, 8'hFF);
        run_random(50);
        wait_idle();

        // Receiver holds off while reads keep coming: the command queue
        // fills and full must hold the sender back.
        tx_idle_on = 1'b0;
        long_hold  = 1'b1;
        send_item(mk(MODE_SET_BAR, 4'd4, 4'd8, 8'd0));
        for (int i = 0; i < 8; i++)
            send_item(mk(MODE_READ, 4'd0, 4'd0, 8'(72 + i)));
        wait_idle();

        tx_idle_on = 1'b1;
        write_regs(8'h00, 8'hFF, 8'h00);
        run_random(50);
        wait_idle();

        write_regs(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(45);
        wait_idle();

        // Closing stretch runs back to back on both sides.
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        write_regs(8'($urandom), 8'($urandom), 8'($urandom));
        run_random(50);
        wait_idle();

        if (sb.errors == 0 && sb.code_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
